FILE: hw/rtl/fir_filter_int16_top_defines.svh
// ----------------------------------------------------------------------------
// fir filter assertion macros
// concurrent assertion wrappers used by the top rtl file of the fir filter
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_INT16_TOP_DEFINES_SVH
`define FIR_FILTER_INT16_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FIR16_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FIR16_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define FIR16_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIR16_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: hw/rtl/fir16_pkg.sv
// ----------------------------------------------------------------------------
// fir16_pkg
// shared constants, types and helpers of the direct-form fir filter
// ----------------------------------------------------------------------------
package fir16_pkg;

  localparam int MAX_TAPS_DEF       = 64;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 15;

  localparam int TAP_COUNT_W = 7;
  localparam int COEF_IDX_W  = 6;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd63;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } fir_state_t;

  typedef struct packed {
    logic acc_init;
    logic coef_we;
    logic sample_we;
    logic rd_en;
    logic rd_dl_ok;
  } mac_ctl_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
  } mac_sts_t;

  function automatic int idx_width(input int taps);
    return (taps > 1) ? $clog2(taps) : 1;
  endfunction

  function automatic int acc_width(input int sbits, input int fbits, input int taps);
    return sbits + fbits + 1 + $clog2(taps);
  endfunction

endpackage

FILE: hw/rtl/fir_filter_int16_top.sv
// ----------------------------------------------------------------------------
// fir_filter_int16_top
// a sample beat reads min(tap_count, MAX_TAPS) taps, one tap per cycle, through the single
//   multiply-accumulate, then drains it and registers the result; with no taps it drains at
//   once; in_stall holds off further beats until the result is loaded into the output register
// coefficient load beats give no result
// reset clears history, coefficients and state; tap_count returns to 63
// ----------------------------------------------------------------------------
`include "fir_filter_int16_top_defines.svh"

module fir_filter_int16_top #(
  parameter int MAX_TAPS       = fir16_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS    = fir16_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = fir16_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [fir16_pkg::TAP_COUNT_W-1:0]    cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic [fir16_pkg::COEF_IDX_W-1:0]     in_coef_index,
  input  logic signed [COEF_FRAC_BITS:0]       in_coef_value,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out
);

  localparam int IDX_W = fir16_pkg::idx_width(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = fir16_pkg::acc_width(SAMPLE_BITS, COEF_FRAC_BITS, MAX_TAPS);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'(((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1) <<< COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] SAT_LO =
    ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1 + COEF_FRAC_BITS)));
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  fir16_pkg::fir_state_t state_r, state_nxt;

  logic [fir16_pkg::TAP_COUNT_W-1:0] tap_count_r;
  logic [IDX_W-1:0]                  wp_r;
  logic [IDX_W-1:0]                  wp_inc;
  logic [CNT_W-1:0]                  fill_r;
  logic [IDX_W-1:0]                  k_r;
  logic [IDX_W-1:0]                  rd_addr_r;
  logic [IDX_W-1:0]                  rd_prev;
  logic [CNT_W-1:0]                  taps_r;
  logic [CNT_W-1:0]                  taps_clamp;
  logic                              k_last;
  logic                              in_beat;
  logic                              smp_beat;
  logic                              load_beat;
  logic                              coef_in_range;
  logic                              out_load;
  logic                              out_valid_r;
  logic signed [SAMPLE_BITS-1:0]     out_data_r;
  logic signed [SAMPLE_BITS-1:0]     out_data_nxt;

  fir16_pkg::mac_ctl_t         ctl;
  fir16_pkg::mac_sts_t         sts;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_biased;
  logic signed [ACC_W-1:0]     acc_shift;

  assign in_beat       = in_valid && !in_stall;
  assign smp_beat      = in_beat && (in_mode == fir16_pkg::MODE_SAMPLE);
  assign load_beat     = in_beat && (in_mode == fir16_pkg::MODE_LOAD);
  assign coef_in_range = int'(in_coef_index) < MAX_TAPS;

  assign taps_clamp = (int'(tap_count_r) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_r);
  assign wp_inc     = (wp_r == IDX_W'(MAX_TAPS - 1)) ? '0 : wp_r + 1'b1;
  assign rd_prev    = (rd_addr_r == '0) ? IDX_W'(MAX_TAPS - 1) : rd_addr_r - 1'b1;
  assign k_last     = (CNT_W'(k_r) + CNT_W'(1)) == taps_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fir16_pkg::ST_IDLE: begin
        if (smp_beat) begin
          state_nxt = (taps_clamp == '0) ? fir16_pkg::ST_DRAIN : fir16_pkg::ST_ISSUE;
        end
      end
      fir16_pkg::ST_ISSUE: begin
        if (k_last) begin
          state_nxt = fir16_pkg::ST_DRAIN;
        end
      end
      fir16_pkg::ST_DRAIN: begin
        if (!sts.s1_vld && !sts.s2_vld) begin
          state_nxt = fir16_pkg::ST_FINISH;
        end
      end
      fir16_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = fir16_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fir16_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = (state_r != fir16_pkg::ST_IDLE);
    ctl.acc_init  = smp_beat;
    ctl.sample_we = smp_beat;
    ctl.coef_we   = load_beat && coef_in_range;
    ctl.rd_en     = (state_r == fir16_pkg::ST_ISSUE);
    ctl.rd_dl_ok  = CNT_W'(k_r) < fill_r;
    out_load      = (state_r == fir16_pkg::ST_FINISH) && (!out_valid_r || !out_stall);
  end

  // a half is folded into the accumulator start value and the sum is then truncated toward zero
  always_comb begin
    acc_biased = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);
    acc_shift  = acc_biased >>> COEF_FRAC_BITS;
    if (acc > SAT_HI) begin
      out_data_nxt = OUT_MAX;
    end else if (acc < SAT_LO) begin
      out_data_nxt = OUT_MIN;
    end else begin
      out_data_nxt = acc_shift[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fir16_pkg::ST_IDLE;
      tap_count_r <= fir16_pkg::TAP_COUNT_RST;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (smp_beat) begin
        wp_r <= wp_inc;
        if (fill_r != CNT_W'(MAX_TAPS)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_beat) begin
      k_r       <= '0;
      rd_addr_r <= wp_inc;
      taps_r    <= taps_clamp;
    end else if (state_r == fir16_pkg::ST_ISSUE) begin
      k_r       <= k_r + 1'b1;
      rd_addr_r <= rd_prev;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  fir16_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cf_wr_addr (IDX_W'(in_coef_index)),
    .cf_wr_data (in_coef_value),
    .dl_wr_addr (wp_inc),
    .dl_wr_data (in_sample_in),
    .rd_cf_addr (k_r),
    .rd_dl_addr (rd_addr_r),
    .sts        (sts),
    .acc        (acc)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  `FIR16_ASSERT_NEXT(a_sample_busy, clk, rst_n, smp_beat, in_stall, "sample beat did not start work")
  `FIR16_ASSERT_NEXT(a_load_idle, clk, rst_n, load_beat, !in_stall, "load beat left idle")
  `FIR16_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == fir16_pkg::ST_FINISH), "result without finish")
  `FIR16_ASSERT(a_finish_drained, clk, rst_n, (state_r == fir16_pkg::ST_FINISH) |-> (!sts.s1_vld && !sts.s2_vld), "finish with mac busy")

endmodule

FILE: hw/rtl/fir16_mac.sv
// ----------------------------------------------------------------------------
// fir16_mac
// coefficient and delay memories with the multiply-accumulate pipeline:
// registered memory read, registered product, accumulate
// ----------------------------------------------------------------------------
module fir16_mac #(
  parameter int MAX_TAPS       = fir16_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS    = fir16_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = fir16_pkg::COEF_FRAC_BITS_DEF,
  localparam int COEF_BITS     = COEF_FRAC_BITS + 1,
  localparam int IDX_W         = fir16_pkg::idx_width(MAX_TAPS),
  localparam int ACC_W         = fir16_pkg::acc_width(SAMPLE_BITS, COEF_FRAC_BITS, MAX_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fir16_pkg::mac_ctl_t           ctl,
  input  logic [IDX_W-1:0]              cf_wr_addr,
  input  logic signed [COEF_BITS-1:0]   cf_wr_data,
  input  logic [IDX_W-1:0]              dl_wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] dl_wr_data,
  input  logic [IDX_W-1:0]              rd_cf_addr,
  input  logic [IDX_W-1:0]              rd_dl_addr,
  output fir16_pkg::mac_sts_t           sts,
  output logic signed [ACC_W-1:0]       acc
);

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  logic signed [COEF_BITS-1:0]   cf_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] dl_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           cf_vld_r;

  logic signed [COEF_BITS-1:0]           cf_q_r;
  logic signed [SAMPLE_BITS-1:0]         dl_q_r;
  logic                                  cf_ok_r;
  logic                                  dl_ok_r;
  logic                                  s1_vld_r;
  logic                                  s2_vld_r;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_r;
  logic signed [ACC_W-1:0]               acc_r;

  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      cf_mem[cf_wr_addr] <= cf_wr_data;
    end
    if (ctl.sample_we) begin
      dl_mem[dl_wr_addr] <= dl_wr_data;
    end
    if (ctl.rd_en) begin
      cf_q_r  <= cf_mem[rd_cf_addr];
      dl_q_r  <= dl_mem[rd_dl_addr];
      cf_ok_r <= cf_vld_r[rd_cf_addr];
      dl_ok_r <= ctl.rd_dl_ok;
    end
  end

  // unwritten coefficients read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_vld_r <= '0;
    end else if (ctl.coef_we) begin
      cf_vld_r[cf_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.rd_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      if (cf_ok_r && dl_ok_r) begin
        prod_r <= dl_q_r * cf_q_r;
      end else begin
        prod_r <= '0;
      end
    end
    if (ctl.acc_init) begin
      acc_r <= ACC_HALF;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign sts.s1_vld = s1_vld_r;
  assign sts.s2_vld = s2_vld_r;
  assign acc        = acc_r;

endmodule
